// File: hdl/gsht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsht_pkg
// Shared types and constants for the generational slot handle table.
// ----------------------------------------------------------------------------
package gsht_pkg;

  localparam int OP_W     = 3;
  localparam int NUM_W    = 9;
  localparam int HGEN_W   = 16;
  localparam int OTYPE_W  = 8;
  localparam int STATUS_W = 2;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 40;
  localparam int CFG_W    = 8;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC     = 3'd0,
    OP_ALLOC_AT  = 3'd1,
    OP_FREE      = 3'd2,
    OP_RESOLVE   = 3'd3,
    OP_LOOKUP    = 3'd4,
    OP_CLEAR_GEN = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_MISS  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  localparam logic CFG_STATIC_COUNT = 1'b0;
  localparam logic CFG_RESERVED     = 1'b1;

endpackage

// File: hdl/generational_slot_handle_table.sv
`timescale 1ns / 1ps
// The input beat is registered and executed in S_EXEC, and its result beat is
// registered; no new beat is taken until the item leaves S_EXEC. The entry's
// generation and type are read from slot RAM at accept; ALLOC/FREE write back.
// Reset: synchronous; clears valid and generation-live bits, config registers and
// the output beat. No clearing pass: a slot whose live bit is off reads gen 0.
// ----------------------------------------------------------------------------
// generational_slot_handle_table
// Handle table with static ids and generation-counted dynamic slots.
// ----------------------------------------------------------------------------
module generational_slot_handle_table #(
  parameter int DYNAMIC_SLOTS = 64,
  parameter int GEN_BITS      = 16,
  parameter int TYPE_BITS     = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // op[2:0], slot_number[11:3], handle_gen[27:12], object_type[35:28], zeros
  input  logic [gsht_pkg::IN_W-1:0]   s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // status[1:0], out_slot_id[10:2], out_gen[26:11], out_type[34:27],
  // out_is_static[35], zeros
  output logic [gsht_pkg::OUT_W-1:0]  m_tdata,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [gsht_pkg::CFG_W-1:0]  cfg_data
);
  import gsht_pkg::*;

  localparam int SLOT_W  = $clog2(DYNAMIC_SLOTS);
  localparam int ENTRY_W = GEN_BITS + TYPE_BITS;
  localparam int CMP_W   = (GEN_BITS > HGEN_W) ? GEN_BITS : HGEN_W;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state;

  logic [7:0] static_count;
  logic [6:0] reserved_slots;

  logic [DYNAMIC_SLOTS-1:0] slot_valid;
  logic [DYNAMIC_SLOTS-1:0] gen_live;

  // Input beat fields
  op_t                 in_op;
  logic [NUM_W-1:0]    in_num;
  logic [HGEN_W-1:0]   in_hgen;
  logic [OTYPE_W-1:0]  in_type;

  // Decode done at accept
  logic                free_found;
  logic [SLOT_W-1:0]   free_slot;
  logic [NUM_W-1:0]    num_diff;
  logic [SLOT_W-1:0]   slot_next;
  logic                range_next;
  logic                static_next;
  logic                below_res_next;

  // Item held for the execute state
  op_t                 op_q;
  logic [NUM_W-1:0]    num_q;
  logic [HGEN_W-1:0]   hgen_q;
  logic [TYPE_BITS-1:0] type_q;
  logic [SLOT_W-1:0]   slot_q;
  logic                range_q;
  logic                static_q;
  logic                below_res_q;
  logic                full_q;

  // RAM
  logic                ram_we;
  logic [SLOT_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;

  logic [GEN_BITS-1:0]  gen_rd;
  logic [TYPE_BITS-1:0] type_rd;
  logic [GEN_BITS-1:0]  gen_inc;
  logic [NUM_W-1:0]     global_id;

  // Result
  status_t             res_status;
  logic [NUM_W-1:0]    res_id;
  logic [GEN_BITS-1:0] res_gen;
  logic [TYPE_BITS-1:0] res_type;
  logic                res_static;
  logic                set_valid;
  logic                clr_valid;
  logic                out_free;
  logic                accept;

  assign in_op   = op_t'(s_tdata[2:0]);
  assign in_num  = s_tdata[11:3];
  assign in_hgen = s_tdata[27:12];
  assign in_type = s_tdata[35:28];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Lowest free slot at or above the reserved count
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = DYNAMIC_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i] && (i >= int'(reserved_slots))) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    num_diff       = in_num - NUM_W'(static_count);
    static_next    = in_num < NUM_W'(static_count);
    below_res_next = 32'(in_num) < 32'(reserved_slots);
    range_next     = 1'b0;
    slot_next      = '0;
    case (in_op)
      OP_ALLOC: begin
        slot_next = free_slot;
      end
      OP_ALLOC_AT, OP_LOOKUP: begin
        slot_next  = SLOT_W'(in_num);
        range_next = 32'(in_num) >= DYNAMIC_SLOTS;
      end
      OP_FREE, OP_RESOLVE: begin
        slot_next  = SLOT_W'(num_diff);
        range_next = 32'(num_diff) >= DYNAMIC_SLOTS;
      end
      default: begin
        slot_next = '0;
      end
    endcase
  end

  assign ram_raddr = (state == S_IDLE) ? slot_next : slot_q;

  gsht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DYNAMIC_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_q),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A slot whose live bit is off reads as generation zero, whatever the RAM holds
  assign gen_rd    = gen_live[slot_q] ? ram_rdata[ENTRY_W-1:TYPE_BITS] : '0;
  assign type_rd   = ram_rdata[TYPE_BITS-1:0];
  assign gen_inc   = gen_rd + GEN_BITS'(1);
  assign global_id = NUM_W'(static_count) + NUM_W'(slot_q);

  always_comb begin
    res_status = ST_MISS;
    res_id     = '0;
    res_gen    = '0;
    res_type   = '0;
    res_static = 1'b0;
    set_valid  = 1'b0;
    clr_valid  = 1'b0;
    ram_wdata  = {gen_rd, type_q};
    case (op_q)
      OP_ALLOC, OP_ALLOC_AT: begin
        if ((op_q == OP_ALLOC) && full_q) begin
          res_status = ST_FULL;
        end else if ((op_q == OP_ALLOC_AT) && range_q) begin
          res_status = ST_RANGE;
        end else begin
          res_status = ST_OK;
          res_id     = global_id;
          res_gen    = gen_rd;
          res_type   = type_q;
          set_valid  = 1'b1;
        end
      end
      OP_FREE: begin
        ram_wdata = {gen_inc, type_rd};
        if (static_q || range_q) begin
          res_status = ST_RANGE;
        end else if (slot_valid[slot_q]) begin
          res_status = ST_OK;
          res_id     = num_q;
          res_gen    = gen_inc;
          clr_valid  = 1'b1;
        end
      end
      OP_RESOLVE: begin
        if (static_q) begin
          if (hgen_q == '0) begin
            res_status = ST_OK;
            res_id     = num_q;
            res_static = 1'b1;
          end
        end else if (range_q) begin
          res_status = ST_RANGE;
        end else if (slot_valid[slot_q] && (CMP_W'(gen_rd) == CMP_W'(hgen_q))) begin
          res_status = ST_OK;
          res_id     = num_q;
          res_gen    = gen_rd;
          res_type   = type_rd;
        end
      end
      OP_LOOKUP: begin
        if (!below_res_q) begin
          res_status = ST_MISS;
        end else if (range_q) begin
          res_status = ST_RANGE;
        end else if (slot_valid[slot_q] && (type_rd == type_q)) begin
          res_status = ST_OK;
          res_id     = global_id;
          res_gen    = gen_rd;
          res_type   = type_rd;
        end
      end
      OP_CLEAR_GEN: begin
        res_status = ST_OK;
      end
      default: begin
        res_status = ST_MISS;
      end
    endcase
  end

  assign ram_we = (state == S_EXEC) && out_free && (set_valid || clr_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      m_tvalid       <= 1'b0;
      static_count   <= '0;
      reserved_slots <= '0;
      slot_valid     <= '0;
      gen_live       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STATIC_COUNT: static_count   <= cfg_data;
          CFG_RESERVED:     reserved_slots <= cfg_data[6:0];
          default:          static_count   <= static_count;
        endcase
      end
      // In S_EXEC a departing beat is replaced by the next one below
      if (m_tvalid && m_tready && (state != S_EXEC)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state       <= S_EXEC;
            op_q        <= in_op;
            num_q       <= in_num;
            hgen_q      <= in_hgen;
            type_q      <= TYPE_BITS'(in_type);
            slot_q      <= slot_next;
            range_q     <= range_next;
            static_q    <= static_next;
            below_res_q <= below_res_next;
            full_q      <= !free_found;
          end
        end
        S_EXEC: begin
          // Hold the item until the output register can take its beat
          if (out_free) begin
            state    <= S_IDLE;
            m_tvalid <= 1'b1;
            m_tdata  <= {4'b0, res_static, OTYPE_W'(res_type), HGEN_W'(res_gen),
                         res_id, res_status};
            if (set_valid) begin
              slot_valid[slot_q] <= 1'b1;
              gen_live[slot_q]   <= 1'b1;
            end
            if (clr_valid) begin
              slot_valid[slot_q] <= 1'b0;
              gen_live[slot_q]   <= 1'b1;
            end
            if (op_q == OP_CLEAR_GEN) begin
              gen_live <= '0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/gsht_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsht_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gsht_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/gsht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsht_checker
// Port-level assertions for the generational slot handle table, bound in.
// ----------------------------------------------------------------------------
module gsht_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // Output beat is dropped by reset
  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result beat survived reset");

  // One item at a time: no input beat right after an accepted one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in execution");

  // Static flag only on a hit
  a_static_hit: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[35]) |-> (m_tdata[1:0] == 2'd0))
    else $error("static flag on a failing result");

  // A failing result carries no id, generation or type
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[1:0] != 2'd0)) |-> (m_tdata[39:2] == '0))
    else $error("failing result with nonzero fields");

  // Stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result beat changed while stalled");

endmodule

bind generational_slot_handle_table gsht_checker u_gsht_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
